// File: hdl/ocg_pkg.sv
package ocg_pkg;

  // Grid geometry.
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;

  // Field widths fixed by the interface.
  localparam int COORD_W   = 16;
  localparam int CELL_W    = 12;
  localparam int CAP_W     = 15;
  localparam int USE_W     = 7;
  localparam int IDX_W     = 6;
  localparam int SQ_W      = 34;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Largest distance magnitude along one axis: grid span plus the full coordinate range.
  localparam int MAX_SPAN = MAX_DIM * 4095 + 65536;
  localparam int MAG_W    = $clog2(MAX_SPAN + 1);
  localparam int CTR_W    = MAG_W + 1;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int RAD_W    = 2 * CAP_W;
  localparam int ROOT_W   = CAP_W;

  localparam logic [SQ_W-1:0] SQ_ONES = {SQ_W{1'b1}};

  // Operation codes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd7;

  // Reset values of the configuration registers.
  localparam logic signed [COORD_W-1:0] RST_X_LOW   = -16'sd3000;
  localparam logic signed [COORD_W-1:0] RST_X_HIGH  = 16'sd3000;
  localparam logic signed [COORD_W-1:0] RST_Y_LOW   = -16'sd3000;
  localparam logic signed [COORD_W-1:0] RST_Y_HIGH  = 16'sd3000;
  localparam logic [CELL_W-1:0]         RST_CELL    = 12'd100;
  localparam logic [CAP_W-1:0]          RST_CAP     = 15'd6000;
  localparam logic [USE_W-1:0]          RST_COLUMNS = 7'd60;
  localparam logic [USE_W-1:0]          RST_ROWS    = 7'd60;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      point_valid;
    logic [IDX_W-1:0]          cell_row;
    logic [IDX_W-1:0]          cell_col;
  } in_item_t;

  typedef struct packed {
    logic [CAP_W-1:0] clearance_mm;
    logic             occupied;
    logic             out_of_grid;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_MUL,
    ST_ROW_LOAD,
    ST_CELLS,
    ST_ROW_NEXT,
    ST_DRAIN,
    ST_READ_CAP,
    ST_READ_LIM,
    ST_READ_CMP,
    ST_SQRT,
    ST_RESULT
  } state_t;

endpackage

// File: hdl/ocg_ram.sv
module ocg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ocg_isqrt.sv
module ocg_isqrt
  import ocg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  value,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  // Restoring square root, one result bit per cycle.
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  val_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              take;

  always_comb begin
    rem_sh = {rem_r[ROOT_W-1:0], val_r[RAD_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// File: hdl/obstacle_clearance_grid_unit.sv
// Obstacle clearance grid. The block keeps, for each cell of a grid of up to
// MAX_ROWS x MAX_COLUMNS cells, the smallest squared distance in millimetres
// from the cell centre to any obstacle point added so far, in one simple
// dual-port RAM (one write port, one read port) with a registered read. Items
// are taken one at a time; in_stall is high while an item is being worked on.
// After reset the block sweeps all DEPTH entries of the store (4096 at a
// 64 x 64 grid) to "no obstacle" and accepts no item until the sweep ends; a
// clear operation takes the same sweep. Adding a point visits every cell in
// use through one shared multiplier, one cell per cycle, with per-row steps
// between the rows; a point that is flagged invalid, falls outside the window
// or meets a zero use count is skipped without a sweep. Reading a cell ends in
// the bit-serial square root unless the cell is occupied or lies outside the
// grid in use, in which case the root is skipped. A finished result
// sits in an output register, so the next item can be transferred while the
// result still waits to be taken. Configuration may be written at any time the
// block is idle; the window, cell size and use counts must not change while an
// item is in progress.
module obstacle_clearance_grid_unit
  import ocg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,

  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic signed [COORD_W-1:0] win_x_low_r, win_x_high_r, win_y_low_r, win_y_high_r;
  logic [CELL_W-1:0]         cell_size_r;
  logic [CAP_W-1:0]          clearance_cap_r;
  logic [USE_W-1:0]          columns_in_use_r, rows_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_low_r      <= RST_X_LOW;
      win_x_high_r     <= RST_X_HIGH;
      win_y_low_r      <= RST_Y_LOW;
      win_y_high_r     <= RST_Y_HIGH;
      cell_size_r      <= RST_CELL;
      clearance_cap_r  <= RST_CAP;
      columns_in_use_r <= RST_COLUMNS;
      rows_in_use_r    <= RST_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW:   win_x_low_r      <= cfg_wdata;
        CFG_X_HIGH:  win_x_high_r     <= cfg_wdata;
        CFG_Y_LOW:   win_y_low_r      <= cfg_wdata;
        CFG_Y_HIGH:  win_y_high_r     <= cfg_wdata;
        CFG_CELL:    cell_size_r      <= cfg_wdata[CELL_W-1:0];
        CFG_CAP:     clearance_cap_r  <= cfg_wdata[CAP_W-1:0];
        CFG_COLUMNS: columns_in_use_r <= cfg_wdata[USE_W-1:0];
        CFG_ROWS:    rows_in_use_r    <= cfg_wdata[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Use counts above the grid size act as the grid size.
  logic [USE_W-1:0] nc_used, nr_used;

  always_comb begin
    nc_used = (int'(columns_in_use_r) > MAX_COLUMNS) ? USE_W'(MAX_COLUMNS)
                                                     : columns_in_use_r;
    nr_used = (int'(rows_in_use_r) > MAX_ROWS) ? USE_W'(MAX_ROWS) : rows_in_use_r;
  end

  // Sequencer and datapath registers.
  state_t                    state_r, state_nxt;
  logic [ADDR_W-1:0]         clr_addr_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [CTR_W-1:0]   cx_r, cy_r;
  logic [COL_W-1:0]          col_r;
  logic [ROW_W-1:0]          row_r;
  logic [ADDR_W-1:0]         row_base_r;

  // Cell pipeline: issue (read), square, then compare and write back.
  logic                      a_valid_r, b_valid_r;
  logic [MAG_W-1:0]          adx_r;
  logic [ADDR_W-1:0]         a_addr_r, b_addr_r;
  logic [SQ_W-1:0]           old_r;
  logic [PROD_W-1:0]         mul_r;
  logic [PROD_W-1:0]         dy2_r;
  logic [RAD_W-1:0]          capsq_r;
  out_item_t                 res_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  // Combinational helpers.
  logic                      in_acc, out_free;
  logic                      pt_ok, oog;
  logic [ADDR_W-1:0]         rd_addr, issue_addr;
  logic signed [CTR_W-1:0]   cs_ext, cx0, cy0, dx, dy;
  logic [MAG_W-1:0]          adx, ady;
  logic                      last_col, last_row, clr_last;
  logic [SUM_W-1:0]          sum;
  logic [SQ_W-1:0]           sq_sat;
  logic [RAD_W-1:0]          v;
  logic                      occ;

  // Shared unit and memory controls.
  logic [MAG_W-1:0]          mul_a;
  logic [PROD_W-1:0]         mul_p;
  logic                      issue;
  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [SQ_W-1:0]           ram_wdata, ram_rdata;
  logic                      sqrt_start, sqrt_busy, sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pt_ok = in_data.point_valid
            && (in_data.point_x >= win_x_low_r) && (in_data.point_x <= win_x_high_r)
            && (in_data.point_y >= win_y_low_r) && (in_data.point_y <= win_y_high_r)
            && (nc_used != '0) && (nr_used != '0);
    oog = (int'(in_data.cell_row) >= int'(nr_used))
          || (int'(in_data.cell_col) >= int'(nc_used));
    rd_addr = ADDR_W'(in_data.cell_row) * ADDR_W'(MAX_COLUMNS)
              + ADDR_W'(in_data.cell_col);

    // Cell centres are stepped by one cell size per column or row.
    cs_ext = $signed(CTR_W'(cell_size_r));
    cx0    = CTR_W'(win_x_low_r) + $signed(CTR_W'(cell_size_r >> 1));
    cy0    = CTR_W'(win_y_low_r) + $signed(CTR_W'(cell_size_r >> 1));
    dx     = cx_r - CTR_W'(px_r);
    dy     = cy_r - CTR_W'(py_r);
    adx    = dx[CTR_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    ady    = dy[CTR_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

    issue_addr = row_base_r + ADDR_W'(col_r);
    last_col   = (int'(col_r) == int'(nc_used) - 1);
    last_row   = (int'(row_r) == int'(nr_used) - 1);
    clr_last   = (clr_addr_r == ADDR_W'(DEPTH - 1));

    // The squared distance saturates before the minimum is taken.
    sum    = SUM_W'(mul_r) + SUM_W'(dy2_r);
    sq_sat = (sum > SUM_W'(SQ_ONES)) ? SQ_ONES : sum[SQ_W-1:0];

    // Read path: cap the stored value, then test against one cell squared.
    v   = (ram_rdata > SQ_W'(capsq_r)) ? capsq_r : ram_rdata[RAD_W-1:0];
    occ = (v < RAD_W'(mul_r[2*CELL_W-1:0]));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_ADD:   state_nxt = pt_ok ? ST_ROW_MUL : ST_IDLE;
            OP_READ:  state_nxt = oog ? ST_RESULT : ST_READ_CAP;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROW_MUL:  state_nxt = ST_ROW_LOAD;
      ST_ROW_LOAD: state_nxt = ST_CELLS;
      ST_CELLS: begin
        if (last_col) begin
          state_nxt = last_row ? ST_DRAIN : ST_ROW_NEXT;
        end
      end
      ST_ROW_NEXT: state_nxt = ST_ROW_MUL;
      ST_DRAIN: begin
        if (!a_valid_r && !b_valid_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ_CAP: state_nxt = ST_READ_LIM;
      ST_READ_LIM: state_nxt = ST_READ_CMP;
      ST_READ_CMP: state_nxt = occ ? ST_RESULT : ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controls for the memory, the multiplier and the square root unit.
  always_comb begin
    issue      = (state_r == ST_CELLS);
    ram_we     = 1'b0;
    ram_waddr  = b_addr_r;
    ram_wdata  = sq_sat;
    ram_re     = 1'b0;
    ram_raddr  = issue_addr;
    sqrt_start = (state_r == ST_READ_CMP) && !occ;

    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = SQ_ONES;
    end else if (b_valid_r && (sq_sat < old_r)) begin
      ram_we = 1'b1;
    end

    if (issue) begin
      ram_re = 1'b1;
    end else if ((state_r == ST_IDLE) && in_acc && (in_data.op == OP_READ)) begin
      ram_re    = 1'b1;
      ram_raddr = rd_addr;
    end

    // A cell in the square stage has the multiplier first.
    if (a_valid_r) begin
      mul_a = adx_r;
    end else begin
      case (state_r)
        ST_ROW_MUL:  mul_a = ady;
        ST_READ_CAP: mul_a = MAG_W'(clearance_cap_r);
        ST_READ_LIM: mul_a = MAG_W'(cell_size_r);
        default:     mul_a = '0;
      endcase
    end
  end

  assign mul_p = mul_a * mul_a;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      a_valid_r <= issue;
      b_valid_r <= a_valid_r;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
      end
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    mul_r    <= mul_p;
    adx_r    <= adx;
    a_addr_r <= issue_addr;
    b_addr_r <= a_addr_r;
    old_r    <= ram_rdata;

    case (state_r)
      ST_IDLE: begin
        px_r       <= in_data.point_x;
        py_r       <= in_data.point_y;
        cx_r       <= cx0;
        cy_r       <= cy0;
        col_r      <= '0;
        row_r      <= '0;
        row_base_r <= '0;
        res_r      <= '{clearance_mm: '0, occupied: 1'b0, out_of_grid: 1'b1};
      end
      ST_ROW_LOAD: dy2_r <= mul_r;
      ST_CELLS: begin
        cx_r  <= cx_r + cs_ext;
        col_r <= col_r + 1'b1;
      end
      ST_ROW_NEXT: begin
        cy_r       <= cy_r + cs_ext;
        row_r      <= row_r + 1'b1;
        row_base_r <= row_base_r + ADDR_W'(MAX_COLUMNS);
        col_r      <= '0;
        cx_r       <= cx0;
      end
      ST_READ_LIM: capsq_r <= mul_r[RAD_W-1:0];
      ST_READ_CMP: begin
        res_r <= '{clearance_mm: '0, occupied: 1'b1, out_of_grid: 1'b0};
      end
      ST_SQRT: begin
        res_r <= '{clearance_mm: sqrt_root, occupied: 1'b0, out_of_grid: 1'b0};
      end
      default: ;
    endcase

    if ((state_r == ST_RESULT) && out_free) begin
      out_data_r <= res_r;
    end
  end

  ocg_ram #(
    .WIDTH (SQ_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ocg_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (v),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

`ifndef SYNTHESIS
  // The store is written only by the clearing sweep or by a cell leaving the pipeline.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) || b_valid_r)
    else $error("store written outside the clear sweep and the cell pipeline");

  // Cells enter the pipeline only from the cell sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> $past(state_r) == ST_CELLS)
    else $error("cell in the pipeline without a sweep");

  // A new item is only taken with nothing in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !a_valid_r && !b_valid_r && !sqrt_busy)
    else $error("item taken while work is still in flight");

  // The square root is never restarted while it runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

  // A result is only produced by the result step of a read.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESULT)
    else $error("result raised outside the result step");
`endif

endmodule

// File: sim/ocg_clearance_checker.sv
`timescale 1ns / 100ps

module ocg_clearance_checker
  import ocg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,

  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,

  output int                   bad_readings,
  output int                   readings_due,
  output int                   readings_checked
);

  logic signed [COORD_W-1:0] x_low, x_high, y_low, y_high;
  logic [CELL_W-1:0]         cell_mm;
  logic [CAP_W-1:0]          cap_mm;
  logic [USE_W-1:0]          cols_used, rows_used;

  // Smallest squared distance seen per cell, indexed row * MAX_COLUMNS + col.
  logic [SQ_W-1:0] nearest_sq [0:DEPTH-1];
  out_item_t       due_q [$];
  int              reported;

  initial begin
    bad_readings     = 0;
    readings_due     = 0;
    readings_checked = 0;
    reported         = 0;
  end

  function automatic int clamp_use(input logic [USE_W-1:0] n, input int most);
    return (int'(n) > most) ? most : int'(n);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root, trial;
    int b;
    root = 0;
    for (b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic wipe_grid();
    for (int i = 0; i < DEPTH; i++) nearest_sq[i] = SQ_ONES;
  endtask

  task automatic fold_obstacle(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py);
    longint          cs, dx, dy;
    longint unsigned adx, ady, sq;
    int              nr, nc, idx;
    if (px < x_low || px > x_high || py < y_low || py > y_high) return;
    cs = longint'(cell_mm);
    nr = clamp_use(rows_used, MAX_ROWS);
    nc = clamp_use(cols_used, MAX_COLUMNS);
    for (int r = 0; r < nr; r++) begin
      dy  = longint'(y_low) + r * cs + cs / 2 - longint'(py);
      ady = (dy < 0) ? -dy : dy;
      for (int c = 0; c < nc; c++) begin
        dx  = longint'(x_low) + c * cs + cs / 2 - longint'(px);
        adx = (dx < 0) ? -dx : dx;
        sq  = adx * adx + ady * ady;
        if (sq > SQ_ONES) sq = SQ_ONES;
        idx = r * MAX_COLUMNS + c;
        if (sq[SQ_W-1:0] < nearest_sq[idx]) nearest_sq[idx] = sq[SQ_W-1:0];
      end
    end
  endtask

  function automatic out_item_t predict_reading(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    out_item_t       r;
    longint unsigned v, ceiling, floor_sq, root;
    r = '0;
    if (int'(row) >= clamp_use(rows_used, MAX_ROWS) ||
        int'(col) >= clamp_use(cols_used, MAX_COLUMNS)) begin
      r.out_of_grid = 1'b1;
      return r;
    end
    v        = nearest_sq[int'(row) * MAX_COLUMNS + int'(col)];
    ceiling  = longint'(cap_mm) * longint'(cap_mm);
    floor_sq = longint'(cell_mm) * longint'(cell_mm);
    if (v > ceiling) v = ceiling;
    if (v < floor_sq) begin
      r.occupied = 1'b1;
    end else begin
      root           = floor_root(v);
      r.clearance_mm = root[CAP_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      x_low     = RST_X_LOW;
      x_high    = RST_X_HIGH;
      y_low     = RST_Y_LOW;
      y_high    = RST_Y_HIGH;
      cell_mm   = RST_CELL;
      cap_mm    = RST_CAP;
      cols_used = RST_COLUMNS;
      rows_used = RST_ROWS;
      wipe_grid();
      due_q.delete();
    end else begin
      // Results are compared before new reads are queued in the same cycle.
      if (out_valid && !out_stall) begin
        readings_checked++;
        if (due_q.size() == 0) begin
          bad_readings++;
          if (reported < 10)
            $display("%0t: result with nothing outstanding: clearance %0d occupied %0b out_of_grid %0b",
                     $time, out_data.clearance_mm, out_data.occupied, out_data.out_of_grid);
          reported++;
        end else begin
          want = due_q.pop_front();
          if (want.clearance_mm !== out_data.clearance_mm ||
              want.occupied !== out_data.occupied ||
              want.out_of_grid !== out_data.out_of_grid) begin
            bad_readings++;
            if (reported < 10)
              $display("%0t: wrong reading: want %0d/%0b/%0b got %0d/%0b/%0b (mm/occ/oog)",
                       $time, want.clearance_mm, want.occupied, want.out_of_grid,
                       out_data.clearance_mm, out_data.occupied, out_data.out_of_grid);
            reported++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_X_LOW:   x_low     = cfg_wdata;
          CFG_X_HIGH:  x_high    = cfg_wdata;
          CFG_Y_LOW:   y_low     = cfg_wdata;
          CFG_Y_HIGH:  y_high    = cfg_wdata;
          CFG_CELL:    cell_mm   = cfg_wdata[CELL_W-1:0];
          CFG_CAP:     cap_mm    = cfg_wdata[CAP_W-1:0];
          CFG_COLUMNS: cols_used = cfg_wdata[USE_W-1:0];
          CFG_ROWS:    rows_used = cfg_wdata[USE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        case (in_data.op)
          OP_CLEAR: wipe_grid();
          OP_ADD:   if (in_data.point_valid) fold_obstacle(in_data.point_x, in_data.point_y);
          OP_READ:  due_q.push_back(predict_reading(in_data.cell_row, in_data.cell_col));
          default: ;
        endcase
      end
    end
    readings_due = due_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the obstacle clearance grid. The checker instance
// beside the block does all prediction and comparison; this module only makes
// traffic on the three ports and decides pass or fail at the end.
module tb_top;
  import ocg_pkg::*;

  // The block ignores op code 3; it is sent on purpose.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A full clear sweeps 4096 entries and a point add on a 64 x 64 grid visits
  // 4096 cells, so this covers any item still in progress.
  localparam int SETTLE_CYCLES  = 4500;
  // Cycles with no transfer on any port before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 40000;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int bad_readings, readings_due, readings_checked;

  // Configuration currently programmed, kept here to aim the random traffic.
  int cur_xl, cur_xh, cur_yl, cur_yh, cur_cols, cur_rows;

  int items_sent  = 0;
  int reads_sent  = 0;
  int adds_sent   = 0;
  int setups_run  = 0;
  int burst_left  = 0;
  int quiet_count = 0;

  always #5 clk = ~clk;

  obstacle_clearance_grid_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ocg_clearance_checker check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .bad_readings     (bad_readings),
    .readings_due     (readings_due),
    .readings_checked (readings_checked)
  );

  // The result side switches between three moods: never stalling, stalling on
  // a coin toss, and long stall runs separated by short open windows. Each mood
  // lasts a random stretch, so stalls land on every phase of the block's work.
  rx_mode_t rx_mode   = RX_FREE;
  int       mode_left = 0;
  int       run_left  = 0;
  logic     run_stall = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          run_left  = run_stall ? $urandom_range(1, 20) : $urandom_range(1, 4);
        end else begin
          run_left--;
        end
        out_stall <= run_stall;
      end
    endcase
  end

  // Watchdog: any transfer, register write or reset restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_count);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Offers one item and holds it until the block takes it. Valid is left high
  // when the burst goes on, so back-to-back transfers need no extra edge.
  task automatic transfer_item(input in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (it.op == OP_READ) reads_sent++;
    if (it.op == OP_ADD) adds_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      // Now and then a long burst, so some stretches carry no sender gaps.
      burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(0, 6);
    end
  endtask

  function automatic in_item_t point_item(input int x, input int y, input logic ok);
    in_item_t it;
    it             = '0;
    it.op          = OP_ADD;
    it.point_x     = x[15:0];
    it.point_y     = y[15:0];
    it.point_valid = ok;
    return it;
  endfunction

  function automatic in_item_t read_item(input int row, input int col);
    in_item_t it;
    it          = '0;
    it.op       = OP_READ;
    it.cell_row = row[IDX_W-1:0];
    it.cell_col = col[IDX_W-1:0];
    return it;
  endfunction

  function automatic in_item_t op_item(input logic [1:0] op);
    in_item_t it;
    it    = '0;
    it.op = op;
    return it;
  endfunction

  // Mostly a coordinate inside the acceptance window, sometimes anything at all.
  function automatic logic [15:0] pick_coord(input int lo, input int hi);
    int v;
    if (hi >= lo && $urandom_range(0, 99) < 85) v = lo + int'($urandom_range(0, hi - lo));
    else v = $urandom;
    return v[15:0];
  endfunction

  // Well-formed traffic dominates: points in the window and reads of cells in
  // use. The rest is invalid points, stray reads, clears, the unused op and
  // fully random items.
  function automatic in_item_t random_item();
    logic [63:0] bits;
    in_item_t    it;
    int          pick, nr, nc;
    bits = {$urandom, $urandom};
    it   = bits[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    nr   = (cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows;
    nc   = (cur_cols > MAX_COLUMNS) ? MAX_COLUMNS : cur_cols;
    if (pick < 40) begin
      it.op          = OP_ADD;
      it.point_valid = ($urandom_range(0, 9) != 0);
      it.point_x     = pick_coord(cur_xl, cur_xh);
      it.point_y     = pick_coord(cur_yl, cur_yh);
    end else if (pick < 85) begin
      it.op = OP_READ;
      if (nr > 0 && nc > 0 && $urandom_range(0, 9) != 0) begin
        it.cell_row = IDX_W'($urandom_range(0, nr - 1));
        it.cell_col = IDX_W'($urandom_range(0, nc - 1));
      end
    end else if (pick < 89) begin
      it.op = OP_CLEAR;
    end else if (pick < 93) begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Holds off the sender until every reading has come back, then lets the block
  // finish any clear or point add that produces no result.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (readings_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
  endtask

  task automatic program_grid(input int xl, input int xh, input int yl, input int yh,
                              input int cs, input int cap, input int cols, input int rows);
    write_reg(CFG_X_LOW, xl);
    write_reg(CFG_X_HIGH, xh);
    write_reg(CFG_Y_LOW, yl);
    write_reg(CFG_Y_HIGH, yh);
    write_reg(CFG_CELL, cs);
    write_reg(CFG_CAP, cap);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    cfg_we   <= 1'b0;
    cur_xl   = xl;
    cur_xh   = xh;
    cur_yl   = yl;
    cur_yh   = yh;
    cur_cols = cols;
    cur_rows = rows;
    setups_run++;
  endtask

  task automatic random_phase(input int xl, input int xh, input int yl, input int yh,
                              input int cs, input int cap, input int cols, input int rows,
                              input int count);
    settle_block();
    program_grid(xl, xh, yl, yh, cs, cap, cols, rows);
    repeat (count) begin
      transfer_item(random_item());
      // Occasionally drain every outstanding reading mid-phase.
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        while (readings_due != 0) @(negedge clk);
        @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on a 16 x 16 grid of 100 mm cells spanning -800..800 on
    // both axes, so cell (r, c) has its centre at (-750 + 100c, -750 + 100r).
    settle_block();
    program_grid(-800, 800, -800, 800, 100, 6000, 16, 16);
    transfer_item(read_item(0, 0));          // empty grid reads back the cap
    transfer_item(read_item(63, 63));        // far outside the cells in use
    transfer_item(read_item(15, 16));        // one column past the edge
    transfer_item(read_item(16, 15));        // one row past the edge
    transfer_item(point_item(0, 0, 1'b0));   // flagged invalid, must be skipped
    transfer_item(read_item(8, 8));
    transfer_item(point_item(-800, -800, 1'b1));  // low corner, window is inclusive
    transfer_item(read_item(0, 0));          // within one cell: occupied
    transfer_item(point_item(801, 0, 1'b1)); // just outside on the right
    transfer_item(point_item(800, 800, 1'b1));    // high corner
    transfer_item(read_item(15, 15));
    transfer_item(read_item(15, 14));
    transfer_item(point_item(32767, -32768, 1'b1));
    transfer_item(point_item(-32768, 32767, 1'b1));
    transfer_item(op_item(OP_UNUSED));
    transfer_item(read_item(7, 7));
    transfer_item(op_item(OP_CLEAR));
    transfer_item(read_item(0, 0));          // back to the cap after the clear
    transfer_item(point_item(0, 0, 1'b1));
    transfer_item(read_item(8, 8));
    transfer_item(read_item(8, 10));

    // Random phases, each with its own setting. The grid is not cleared between
    // them, so cells left out by small use counts show up again later.
    random_phase(-400, 400, -300, 500, 50, 300, 12, 10, 25);
    random_phase(-600, 600, -600, 600, 200, 150, 6, 5, 12);        // cap below cell size
    random_phase(-100, 100, -100, 100, 0, 32767, 10, 10, 12);      // zero cell size
    random_phase(500, -500, -300, 300, 80, 4000, 8, 8, 10);        // empty x window
    random_phase(-640, 640, -640, 640, 20, 2000, 127, 100, 10);    // counts above grid size
    random_phase(-300, 300, -300, 300, 60, 1000, 0, 127, 8);       // no columns in use
    random_phase(0, 0, 0, 0, 1, 0, 1, 1, 10);                      // single-point window, zero cap
    random_phase(-32768, 32767, -32768, 32767, 4095, 32767, 64, 64, 8);
    random_phase(-2000, 2000, -100, 300, 37, 5000, 40, 3, 25);
    random_phase(-1000, 1000, -1000, 1000, 250, 3000, 7, 0, 6);    // no rows in use

    settle_block();

    $display("Sent %0d items (%0d point adds, %0d cell reads) over %0d grid settings.",
             items_sent, adds_sent, reads_sent, setups_run);
    $display("Compared %0d readings; %0d were wrong or unexpected, %0d never arrived.",
             readings_checked, bad_readings, readings_due);
    if (bad_readings == 0 && readings_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ocg_pkg.sv
hdl/ocg_ram.sv
hdl/ocg_isqrt.sv
hdl/obstacle_clearance_grid_unit.sv
sim/ocg_clearance_checker.sv
sim/tb_top.sv
